// ----- rtl/lir_pkg.sv -----
// shared constants, types and helpers of the linear interpolation resampler
package lir_pkg;

    localparam int FRAME_MAX   = 4096;
    localparam int TABLE_ROWS  = 256;
    localparam int SAMPLE_W    = 16;
    localparam int FRAC_W      = 32;
    localparam int INC_W       = 40;
    localparam int PHASE_W     = 45;
    localparam int LEN_W       = 13;
    localparam int CNT_W       = 12;
    localparam int IDX_W       = PHASE_W - FRAC_W;
    localparam int ROW_W       = $clog2(TABLE_ROWS);
    localparam int MAX_RESULTS = 64;
    localparam int RUN_W       = $clog2(MAX_RESULTS);
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int PROD_W      = DIFF_W + ROW_W + 1;
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH  = 4;
    localparam int RESQ_PTR_W  = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT_W  = $clog2(RESQ_DEPTH + 1);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = INC_W;

    localparam logic [INC_W-1:0] INC_RESET = INC_W'(64'd1 << FRAC_W);
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(FRAME_MAX);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_INC = 1'b0,
        REG_FRAME_LEN = 1'b1
    } t_reg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] cur;
        logic signed [SAMPLE_W-1:0] prev;
        logic [CNT_W-1:0]           j;
        logic                       last;
        logic [LEN_W-1:0]           limit;
    } t_cmd;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       last_of_run;
        logic                       frame_done;
    } t_res;

    typedef struct packed {
        logic last_of_run;
        logic frame_done;
    } t_flags;

    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] fl);
        logic [LEN_W-1:0] r;
        if (fl == '0) begin
            r = LEN_W'(1);
        end else if (fl > LEN_W'(FRAME_MAX)) begin
            r = LEN_W'(FRAME_MAX);
        end else begin
            r = fl;
        end
        return r;
    endfunction

endpackage

// ----- rtl/lir_cmd_queue.sv -----
// short command queue between the front and the back of the resampler
module lir_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lir_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output lir_pkg::t_cmd o_data,
    output logic          o_empty
);
    import lir_pkg::*;

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr;
    logic [CMDQ_PTR_W-1:0] r_rd;
    logic [CMDQ_CNT_W-1:0] r_cnt;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_cnt == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + CMDQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + CMDQ_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CMDQ_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CMDQ_CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/lir_front.sv -----
// input side: counts samples of the frame and classifies each one
module lir_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [lir_pkg::LEN_W-1:0]          i_len,
    input  logic                               i_q_pop,
    output lir_pkg::t_cmd                      o_q_data,
    output logic                               o_q_empty
);
    import lir_pkg::*;

    logic [CNT_W-1:0]           r_icnt;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic                       accept;
    logic [LEN_W-1:0]           j_next;
    logic                       is_last;
    t_cmd                       cmd;

    assign accept  = i_push && !o_full;
    assign j_next  = LEN_W'(r_icnt) + LEN_W'(1);
    assign is_last = (j_next >= i_len);

    always_comb begin
        cmd.cur   = i_sample;
        cmd.prev  = r_prev;
        cmd.j     = r_icnt;
        cmd.last  = is_last;
        cmd.limit = is_last ? j_next : LEN_W'(r_icnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_icnt <= '0;
            r_prev <= '0;
        end else if (accept) begin
            r_icnt <= is_last ? '0 : r_icnt + CNT_W'(1);
            r_prev <= i_sample;
        end
    end

    lir_cmd_queue u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (i_q_pop),
        .o_data  (o_q_data),
        .o_empty (o_q_empty)
    );

endmodule

// ----- rtl/lir_back.sv -----
// output side: steps the read phase and interpolates one result per cycle while the result queue has room
module lir_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [lir_pkg::INC_W-1:0]         i_inc,
    input  logic [lir_pkg::LEN_W-1:0]         i_len,
    input  lir_pkg::t_cmd                     i_q_data,
    input  logic                              i_q_empty,
    output logic                              o_q_pop,
    input  logic [lir_pkg::RESQ_CNT_W-1:0]    i_res_cnt,
    output logic                              o_res_we,
    output lir_pkg::t_res                     o_res
);
    import lir_pkg::*;

    logic                       r_busy;
    t_cmd                       r_cmd;
    logic [RUN_W-1:0]           r_n;
    logic [PHASE_W-1:0]         r_phase;
    logic [LEN_W-1:0]           r_ocnt;

    logic                       r_va;
    logic signed [SAMPLE_W-1:0] r_a;
    logic signed [DIFF_W-1:0]   r_d;
    logic [ROW_W-1:0]           r_row;
    t_flags                     r_fa;

    logic                       r_vb;
    logic signed [SAMPLE_W-1:0] r_ab;
    logic signed [PROD_W-1:0]   r_prod;
    t_flags                     r_fb;

    logic [IDX_W-1:0]           idx;
    logic                       cont;
    logic [PHASE_W-1:0]         n_phase;
    logic [LEN_W-1:0]           n_ocnt;
    logic                       cont_nx;
    logic                       run_full;
    logic                       is_final;
    logic                       over;
    logic [RESQ_CNT_W:0]        in_use;
    logic                       space;
    logic                       issue;
    logic                       finish;
    logic signed [SAMPLE_W-1:0] a_sel;
    t_flags                     flags;
    logic signed [PROD_W-1:0]   sum;
    logic signed [PROD_W-1:0]   rnd;

    assign o_q_pop  = !r_busy && !i_q_empty;

    assign idx      = r_phase[PHASE_W-1:FRAC_W];
    assign cont     = (r_ocnt < i_len) && (LEN_W'(idx) < r_cmd.limit);
    assign n_phase  = r_phase + PHASE_W'(i_inc);
    assign n_ocnt   = r_ocnt + LEN_W'(1);
    assign cont_nx  = (n_ocnt < i_len) && (LEN_W'(n_phase[PHASE_W-1:FRAC_W]) < r_cmd.limit);
    assign run_full = (r_n == RUN_W'(MAX_RESULTS - 1));
    assign is_final = !cont_nx || run_full;
    assign over     = run_full && cont_nx;

    assign in_use   = (RESQ_CNT_W+1)'(i_res_cnt) + (RESQ_CNT_W+1)'(r_va)
                    + (RESQ_CNT_W+1)'(r_vb);
    assign space    = in_use < (RESQ_CNT_W+1)'(RESQ_DEPTH);
    assign issue    = r_busy && cont && space;
    assign finish   = (r_busy && !cont) || (issue && is_final);

    assign a_sel    = (LEN_W'(idx) >= LEN_W'(r_cmd.j)) ? r_cmd.cur : r_cmd.prev;

    always_comb begin
        flags.last_of_run = is_final;
        flags.frame_done  = (n_ocnt >= i_len) || over || (is_final && r_cmd.last);
    end

    // sequencer over the outputs of one sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_n     <= '0;
            r_phase <= '0;
            r_ocnt  <= '0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_n    <= '0;
            end
            if (issue) begin
                r_n     <= r_n + RUN_W'(1);
                r_phase <= n_phase;
                r_ocnt  <= over ? i_len : n_ocnt;
            end
            if (finish) begin
                r_busy <= 1'b0;
                if (r_cmd.last) begin
                    r_phase <= '0;
                    r_ocnt  <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_data;
        end
    end

    // interpolation pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= issue;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= a_sel;
        r_d    <= DIFF_W'(r_cmd.cur) - DIFF_W'(a_sel);
        r_row  <= r_phase[FRAC_W-1 -: ROW_W];
        r_fa   <= flags;
        r_ab   <= r_a;
        r_prod <= PROD_W'(r_d) * $signed(PROD_W'(r_row));
        r_fb   <= r_fa;
    end

    // a*rows + (b-a)*row, then divide by rows truncating toward zero
    assign sum = $signed({{(PROD_W-SAMPLE_W-ROW_W){r_ab[SAMPLE_W-1]}}, r_ab, ROW_W'(0)}) + r_prod;
    assign rnd = sum + (sum[PROD_W-1] ? PROD_W'(TABLE_ROWS - 1) : PROD_W'(0));

    assign o_res_we = r_vb;
    always_comb begin
        o_res.out_sample  = rnd[ROW_W +: SAMPLE_W];
        o_res.last_of_run = r_fb.last_of_run;
        o_res.frame_done  = r_fb.frame_done;
    end

endmodule

// ----- rtl/lir_res_queue.sv -----
// result queue that faces the output ports
module lir_res_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  lir_pkg::t_res                  i_data,
    output logic [lir_pkg::RESQ_CNT_W-1:0] o_cnt,
    input  logic                           i_pop,
    output lir_pkg::t_res                  o_data,
    output logic                           o_empty
);
    import lir_pkg::*;

    t_res                  r_mem [RESQ_DEPTH];
    logic [RESQ_PTR_W-1:0] r_wr;
    logic [RESQ_PTR_W-1:0] r_rd;
    logic [RESQ_CNT_W-1:0] r_cnt;
    logic                  do_pop;

    assign o_cnt   = r_cnt;
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_we) begin
                r_wr <= r_wr + RESQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + RESQ_PTR_W'(1);
            end
            if (i_we && !do_pop) begin
                r_cnt <= r_cnt + RESQ_CNT_W'(1);
            end else if (do_pop && !i_we) begin
                r_cnt <= r_cnt - RESQ_CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/linear_interp_resampler.sv -----
// top level of the linear interpolation resampler with its config registers
// path: a request goes through the command queue, the back sequencer, the 2-stage
//   multiply and the result queue; the back sequencer loads one sample at a time
//   and issues its results one per cycle while the result queue has room
// reset: synchronous active low; clears phase, counts and queues, sets the
//   increment to 1.0 and the frame length to 4096
module linear_interp_resampler (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [lir_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [lir_pkg::SAMPLE_W-1:0]  o_out_sample,
    output logic                                 o_last_of_run,
    output logic                                 o_frame_done,
    input  logic                                 i_cfg_we,
    input  logic [lir_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lir_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import lir_pkg::*;

    logic [INC_W-1:0]      r_inc;
    logic [LEN_W-1:0]      r_flen;
    logic [LEN_W-1:0]      len;
    t_cmd                  q_data;
    logic                  q_empty;
    logic                  q_pop;
    logic [RESQ_CNT_W-1:0] res_cnt;
    logic                  res_we;
    t_res                  res_in;
    t_res                  res_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc  <= INC_RESET;
            r_flen <= LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_PHASE_INC: r_inc  <= i_cfg_data[INC_W-1:0];
                REG_FRAME_LEN: r_flen <= i_cfg_data[LEN_W-1:0];
            endcase
        end
    end

    assign len = eff_len(r_flen);

    lir_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_sample  (i_sample),
        .i_len     (len),
        .i_q_pop   (q_pop),
        .o_q_data  (q_data),
        .o_q_empty (q_empty)
    );

    lir_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_inc     (r_inc),
        .i_len     (len),
        .i_q_data  (q_data),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_res_cnt (res_cnt),
        .o_res_we  (res_we),
        .o_res     (res_in)
    );

    lir_res_queue u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (res_we),
        .i_data  (res_in),
        .o_cnt   (res_cnt),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_out_sample  = res_out.out_sample;
    assign o_last_of_run = res_out.last_of_run;
    assign o_frame_done  = res_out.frame_done;

endmodule

// ----- rtl/lir_checker.sv -----
// port-level checks of the resampler and their binding to the top level
module lir_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    input  logic                                full,
    input  logic                                empty,
    input  logic                                pop,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] o_out_sample,
    input  logic                                o_last_of_run,
    input  logic                                o_frame_done
);
    import lir_pkg::*;

    // queues come out of reset drained
    a_reset_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (empty && !full))
        else $error("queues not drained after reset");

    // the end of a frame always closes the run of its sample
    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_done) |-> o_last_of_run)
        else $error("frame_done without last_of_run");

    // a waiting result holds until taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_sample)
            && $stable(o_last_of_run) && $stable(o_frame_done)))
        else $error("waiting result changed");

    // full only rises after a request
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!full && !push) |=> !full)
        else $error("full rose without a request");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (.*);
